### rtl/tps_pkg.sv
package tps_pkg;

  localparam int QueueDepthDefault = 16;

  localparam logic [15:0] BacklogReset = 16'd1200;
  localparam logic [15:0] MinFreqReset = 16'd100;
  localparam logic [15:0] MaxFreqReset = 16'd10000;
  localparam logic [26:0] TimerClockReset = 27'd1000000;
  localparam logic [7:0] HoldDutyReset = 8'd50;

  localparam int CfgIdxW = 2;
  localparam int CfgDataW = 27;

  typedef enum logic [2:0] {
    OP_TICK = 3'd0,
    OP_PUSH = 3'd1,
    OP_HOLD_START = 3'd2,
    OP_HOLD_STOP = 3'd3,
    OP_STOP_ALL = 3'd4
  } opcode_t;

  typedef enum logic [1:0] {
    REG_BACKLOG = 2'd0,
    REG_MIN_FREQ = 2'd1,
    REG_MAX_FREQ = 2'd2,
    REG_TIMER_CLK = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [15:0] hz;
    logic [15:0] on;
    logic [15:0] off;
    logic [7:0] rep;
    logic [7:0] duty;
  } tone_t;

  typedef struct packed {
    logic [2:0] opcode;
    logic [15:0] freq_hz;
    logic [15:0] on_time_ms;
    logic [15:0] off_time_ms;
    logic [7:0] repeat_count;
    logic [7:0] duty_percent;
  } in_item_t;

  typedef struct packed {
    logic pwm_running;
    logic [15:0] pwm_reload;
    logic [15:0] pwm_compare;
    logic busy_res;
    logic [3:0] queue_free;
  } out_item_t;

  typedef struct packed {
    logic [CfgIdxW-1:0] index;
    logic [CfgDataW-1:0] data;
  } cfg_item_t;

endpackage

### rtl/tps_stream_if.sv
interface tps_stream_if #(parameter type payload_t = logic);
  logic valid;
  logic ready;
  payload_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

### rtl/tone_pattern_sequencer.sv
// Processing, from an input beat to its result beat: a plain command goes straight to the result;
// a tick that starts a tone and a hold start run the 27-step reload divider, then the compare
// multiply and a reciprocal divide by 100; a push runs the duplicate check, the backlog walk
// and the oldest-entry drops, walking the queued entries one at a time.
// Throughput: one beat at a time; the input is ready again the cycle after the result beat.
// Reset: rst_n is synchronous and active low; it restores register defaults, empties the
// queue, idles the player and stops the PWM. Queue storage is not cleared.
module tone_pattern_sequencer #(
  parameter int QUEUE_DEPTH = tps_pkg::QueueDepthDefault
) (
  input logic clk,
  input logic rst_n,
  tps_stream_if.sink in_ch,
  tps_stream_if.source out_ch,
  tps_stream_if.sink cfg_ch
);
  import tps_pkg::*;

  localparam int PtrW = $clog2(QUEUE_DEPTH);
  localparam int CntW = $clog2(QUEUE_DEPTH + 1);

  // x/100 as (x*ceil(2^30/100))>>30, exact for every x below 2^23.
  localparam logic [23:0] RecipDiv100 = 24'd10737419;

  typedef enum logic [3:0] {
    S_IDLE, S_DISPATCH, S_DUP_RD, S_DUP_CHK, S_SUM_RD, S_SUM_ACC, S_DROP_RD, S_DROP_CHK,
    S_STORE, S_TICK_RD, S_LOAD, S_DIV, S_MUL, S_CMP, S_OUT
  } state_t;

  // Registers.
  state_t state_r;
  logic [15:0] backlog_cfg_r, min_freq_r, max_freq_r;
  logic [26:0] timer_clk_r;
  tone_t mem_r [QUEUE_DEPTH];
  tone_t rd_data_r, tone_r, cur_r;
  logic [PtrW-1:0] wptr_r, rptr_r, scan_r;
  logic [CntW-1:0] used_r;
  logic [1:0] phase_r;
  logic [15:0] ms_left_r;
  logic hold_r;
  logic pwm_on_r;
  logic [15:0] reload_r, compare_r;
  in_item_t item_r;
  logic [39:0] acc_r;
  logic [39:0] add_r;
  logic [26:0] quo_r, rem_r;
  logic [15:0] div_d_r;
  logic [4:0] step_r;
  logic [7:0] duty_r;
  logic [23:0] prod_r;
  logic [46:0] recip_r;
  out_item_t out_r;

  localparam logic [1:0] PhIdle = 2'd0;
  localparam logic [1:0] PhOn = 2'd1;
  localparam logic [1:0] PhOff = 2'd2;

  // Duration of an entry: on*rep + off*(rep-1).
  function automatic logic [39:0] dur(tone_t e);
    logic [39:0] r;
    r = '0;
    if (e.rep != 8'd0)
      r = 40'(e.on) * 40'(e.rep) + 40'(e.off) * 40'(e.rep - 8'd1);
    return r;
  endfunction

  logic [PtrW-1:0] wnext, rnext, wprev;
  assign wnext = (wptr_r == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wptr_r + 1'b1;
  assign rnext = (rptr_r == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rptr_r + 1'b1;
  assign wprev = (wptr_r == '0) ? PtrW'(QUEUE_DEPTH - 1) : wptr_r - 1'b1;

  logic [PtrW-1:0] scan_next;
  assign scan_next = (scan_r == PtrW'(QUEUE_DEPTH - 1)) ? '0 : scan_r + 1'b1;

  logic [15:0] hz_clamp;
  logic [7:0] duty_clamp;
  logic [16:0] period;
  logic [27:0] rem_sh;
  logic [15:0] reload_calc;
  logic [16:0] cmp_q;
  logic over;

  always_comb begin
    hz_clamp = tone_r.hz;
    if (hz_clamp < min_freq_r) hz_clamp = min_freq_r;
    if (hz_clamp > max_freq_r) hz_clamp = max_freq_r;
    duty_clamp = tone_r.duty;
    if (duty_clamp < 8'd1) duty_clamp = 8'd1;
    if (duty_clamp > 8'd99) duty_clamp = 8'd99;
    rem_sh = {rem_r, quo_r[26]};
    if (quo_r == '0) reload_calc = 16'd0;
    else if (quo_r > 27'd65536) reload_calc = 16'hFFFF;
    else reload_calc = 16'(quo_r - 27'd1);
    period = {1'b0, reload_r} + 17'd1;
    cmp_q = recip_r[46:30];
    over = (acc_r + add_r) > {24'd0, backlog_cfg_r};
  end

  // Main sequencer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      backlog_cfg_r <= BacklogReset;
      min_freq_r <= MinFreqReset;
      max_freq_r <= MaxFreqReset;
      timer_clk_r <= TimerClockReset;
      wptr_r <= '0;
      rptr_r <= '0;
      used_r <= '0;
      phase_r <= PhIdle;
      ms_left_r <= '0;
      cur_r <= '0;
      hold_r <= 1'b0;
      pwm_on_r <= 1'b0;
      reload_r <= '0;
      compare_r <= '0;
      step_r <= '0;
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_reg_t'(cfg_ch.data.index))
          REG_BACKLOG: backlog_cfg_r <= cfg_ch.data.data[15:0];
          REG_MIN_FREQ: min_freq_r <= cfg_ch.data.data[15:0];
          REG_MAX_FREQ: max_freq_r <= cfg_ch.data.data[15:0];
          REG_TIMER_CLK: timer_clk_r <= cfg_ch.data.data;
          default: ;
        endcase
      end
      case (state_r)
        S_IDLE: begin
          if (in_ch.valid) begin
            item_r <= in_ch.data;
            state_r <= S_DISPATCH;
          end
        end
        S_DISPATCH: begin
          tone_r <= '{item_r.freq_hz, item_r.on_time_ms, item_r.off_time_ms,
                      item_r.repeat_count, item_r.duty_percent};
          state_r <= S_OUT;
          case (opcode_t'(item_r.opcode))
            OP_TICK: begin
              if (!hold_r) begin
                if (phase_r == PhIdle) begin
                  if (used_r == '0) pwm_on_r <= 1'b0;
                  else state_r <= S_TICK_RD;
                end else begin
                  if (ms_left_r > 16'd1) ms_left_r <= ms_left_r - 16'd1;
                  else if (phase_r == PhOn && cur_r.off != 16'd0) begin
                    pwm_on_r <= 1'b0;
                    ms_left_r <= cur_r.off;
                    phase_r <= PhOff;
                  end else begin
                    if (phase_r == PhOn) pwm_on_r <= 1'b0;
                    if (cur_r.rep > 8'd1) begin
                      cur_r.rep <= cur_r.rep - 8'd1;
                      tone_r <= cur_r;
                      ms_left_r <= cur_r.on;
                      phase_r <= PhOn;
                      state_r <= S_LOAD;
                    end else begin
                      cur_r.rep <= 8'd0;
                      ms_left_r <= 16'd0;
                      phase_r <= PhIdle;
                    end
                  end
                end
              end
            end
            OP_PUSH: begin
              if (item_r.repeat_count != 8'd0) begin
                if (used_r != '0) begin
                  scan_r <= wprev;
                  state_r <= S_DUP_RD;
                end else begin
                  acc_r <= '0;
                  state_r <= S_SUM_RD;
                  scan_r <= rptr_r;
                end
              end
            end
            OP_HOLD_START: begin
              hold_r <= 1'b1;
              state_r <= S_LOAD;
            end
            OP_HOLD_STOP: begin
              hold_r <= 1'b0;
              pwm_on_r <= 1'b0;
            end
            OP_STOP_ALL: begin
              phase_r <= PhIdle;
              ms_left_r <= '0;
              wptr_r <= '0;
              rptr_r <= '0;
              used_r <= '0;
              hold_r <= 1'b0;
              pwm_on_r <= 1'b0;
            end
            default: ;
          endcase
        end
        S_DUP_RD: state_r <= S_DUP_CHK;
        S_DUP_CHK: begin
          if (rd_data_r == tone_r) state_r <= S_OUT;
          else begin
            acc_r <= '0;
            scan_r <= rptr_r;
            step_r <= '0;
            state_r <= S_SUM_RD;
          end
        end
        // Walk the queue and total the queued play time.
        S_SUM_RD: begin
          add_r <= dur(tone_r);
          if (scan_r == wptr_r || used_r == '0) state_r <= S_DROP_CHK;
          else state_r <= S_SUM_ACC;
        end
        S_SUM_ACC: begin
          acc_r <= acc_r + dur(rd_data_r);
          scan_r <= scan_next;
          state_r <= S_SUM_RD;
        end
        S_DROP_RD: state_r <= S_DROP_CHK;
        S_DROP_CHK: begin
          if (over && used_r != '0) begin
            if (state_r == S_DROP_CHK && scan_r == rptr_r) begin
              acc_r <= acc_r - dur(rd_data_r);
              rptr_r <= rnext;
              used_r <= used_r - 1'b1;
              scan_r <= rnext;
              state_r <= S_DROP_RD;
            end else begin
              scan_r <= rptr_r;
              state_r <= S_DROP_RD;
            end
          end else begin
            if (over) begin
              if (tone_r.rep > 8'd1) tone_r.rep <= 8'd1;
              tone_r.off <= 16'd0;
              if (tone_r.on > backlog_cfg_r) tone_r.on <= backlog_cfg_r;
            end
            state_r <= S_STORE;
          end
        end
        S_STORE: begin
          wptr_r <= wnext;
          if (used_r == CntW'(QUEUE_DEPTH - 1)) rptr_r <= rnext;
          else used_r <= used_r + 1'b1;
          state_r <= S_OUT;
        end
        S_TICK_RD: begin
          cur_r <= rd_data_r;
          tone_r <= rd_data_r;
          ms_left_r <= rd_data_r.on;
          phase_r <= PhOn;
          rptr_r <= rnext;
          used_r <= used_r - 1'b1;
          state_r <= S_LOAD;
        end
        // Reload = clock / clamped hz - 1, saturated to 16 bits; one quotient bit per cycle.
        S_LOAD: begin
          duty_r <= duty_clamp;
          div_d_r <= hz_clamp;
          quo_r <= timer_clk_r;
          rem_r <= '0;
          step_r <= '0;
          state_r <= S_DIV;
        end
        S_DIV: begin
          if (div_d_r == 16'd0) begin
            reload_r <= 16'hFFFF;
            state_r <= S_MUL;
          end else begin
            if (rem_sh >= {12'd0, div_d_r}) begin
              rem_r <= 27'(rem_sh - {12'd0, div_d_r});
              quo_r <= {quo_r[25:0], 1'b1};
            end else begin
              rem_r <= rem_sh[26:0];
              quo_r <= {quo_r[25:0], 1'b0};
            end
            step_r <= step_r + 5'd1;
            if (step_r == 5'd26) state_r <= S_CMP;
          end
        end
        S_CMP: begin
          reload_r <= reload_calc;
          state_r <= S_MUL;
        end
        S_MUL: begin
          prod_r <= 24'(period * duty_r);
          state_r <= S_OUT;
          step_r <= 5'd30;
        end
        // Steps 30 and 31 finish the compare value before the result beat is offered.
        S_OUT: begin
          if (step_r == 5'd30) begin
            recip_r <= 47'(prod_r) * 47'(RecipDiv100);
            step_r <= 5'd31;
          end else if (step_r == 5'd31) begin
            step_r <= '0;
            if (cmp_q >= period || (cmp_q == '0 && period == 17'd1))
              compare_r <= 16'(period - 17'd1);
            else if (cmp_q == '0) compare_r <= 16'd1;
            else compare_r <= cmp_q[15:0];
            pwm_on_r <= 1'b1;
          end else if (out_ch.valid && out_ch.ready) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // Queue memory, one write and one registered read port.
  always_ff @(posedge clk) begin
    if (state_r == S_STORE) mem_r[wptr_r] <= tone_r;
    rd_data_r <= mem_r[(state_r == S_DISPATCH) ? rptr_r : scan_r];
  end

  always_comb begin
    out_r.pwm_running = pwm_on_r;
    out_r.pwm_reload = reload_r;
    out_r.pwm_compare = compare_r;
    out_r.busy_res = hold_r || phase_r != PhIdle || used_r != '0;
    out_r.queue_free = 4'(CntW'(QUEUE_DEPTH - 1) - used_r);
  end

  assign in_ch.ready = state_r == S_IDLE;
  assign out_ch.valid = state_r == S_OUT && step_r < 5'd30;
  assign out_ch.data = out_r;
  assign cfg_ch.ready = 1'b1;

endmodule
